// ----- hdl/rai_pkg.sv -----
// Shared types and codes for the ray and flat ring intersection block.
package rai_pkg;

	typedef logic signed [31:0] coord_t;

	typedef struct packed {
		coord_t origin_x;
		coord_t origin_y;
		coord_t origin_z;
		coord_t dir_x;
		coord_t dir_y;
		coord_t dir_z;
	} ray_t;

	typedef struct packed {
		logic        hit_flag;
		logic [1:0]  miss_reason;
		logic [30:0] hit_distance;
	} res_t;

	typedef struct packed {
		coord_t [2:0] p;
		coord_t [2:0] d;
		logic [1:0]   reason;
		logic         ovf;
	} item_t;

	localparam logic [1:0] REASON_HIT      = 2'd0;
	localparam logic [1:0] REASON_PARALLEL = 2'd1;
	localparam logic [1:0] REASON_BEHIND   = 2'd2;
	localparam logic [1:0] REASON_OUTSIDE  = 2'd3;

	localparam logic [2:0] REG_CENTER_X  = 3'd0;
	localparam logic [2:0] REG_CENTER_Y  = 3'd1;
	localparam logic [2:0] REG_CENTER_Z  = 3'd2;
	localparam logic [2:0] REG_NORMAL_X  = 3'd3;
	localparam logic [2:0] REG_NORMAL_Y  = 3'd4;
	localparam logic [2:0] REG_NORMAL_Z  = 3'd5;
	localparam logic [2:0] REG_INNER_SQ  = 3'd6;
	localparam logic [2:0] REG_OUTER_SQ  = 3'd7;

	localparam logic [30:0] T_MAX    = 31'h7fffffff;
	localparam logic [64:0] SQ_LIMIT = 65'd3037000499;

endpackage

// ----- hdl/rai_if.sv -----
// Ray and result channel interfaces.
interface rai_ray_if import rai_pkg::*; ();
	logic valid;
	logic ready;
	ray_t data;
	modport src(output valid, output data, input ready);
	modport snk(input valid, input data, output ready);
endinterface

interface rai_res_if import rai_pkg::*; ();
	logic valid;
	logic ready;
	res_t data;
	modport src(output valid, output data, input ready);
	modport snk(input valid, input data, output ready);
endinterface

// ----- hdl/rai_div_cell.sv -----
// One restoring division cell that settles a single quotient bit.
module rai_div_cell import rai_pkg::*; #(
	parameter int W = 84,
	parameter int K = 0
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         v_in,
	input  logic [W-1:0] r_in,
	input  logic [W-1:0] b_in,
	input  logic [30:0]  q_in,
	input  item_t        it_in,
	output logic         v_q,
	output logic [W-1:0] r_q,
	output logic [W-1:0] b_q,
	output logic [30:0]  q_q,
	output item_t        it_q
);
	logic [W:0] trial;

	assign trial = {1'b0, r_in} - {1'b0, (b_in << K)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b_q  <= b_in;
			it_q <= it_in;
			if (!trial[W]) begin
				r_q <= trial[W-1:0];
				q_q <= q_in | (31'd1 << K);
			end else begin
				r_q <= r_in;
				q_q <= q_in;
			end
		end
	end
endmodule

// ----- hdl/rai_axis.sv -----
// Per-axis hit point and squared offset from the ring center, three stages.
module rai_axis import rai_pkg::*; #(
	parameter int FRACTION_BITS = 16
) (
	input  logic        clk,
	input  logic        en,
	input  logic [30:0] t,
	input  coord_t      p,
	input  coord_t      d,
	input  coord_t      c,
	output logic [63:0] sq_s3,
	output logic        big_s3
);
	logic signed [63:0] prod_s1;
	coord_t             p_s1;
	logic signed [63:0] pt;
	logic signed [64:0] diff;
	logic [64:0]        mag;
	logic [31:0]        m_s2;
	logic               big_s2;

	always_comb begin
		pt   = 64'(p_s1) + (prod_s1 >>> FRACTION_BITS);
		diff = 65'(c) - 65'(pt);
		mag  = diff[64] ? 65'(-diff) : 65'(diff);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= $signed({1'b0, t}) * d;
			p_s1    <= p;
			m_s2    <= mag[31:0];
			big_s2  <= mag > SQ_LIMIT;
			sq_s3   <= 64'(m_s2) * 64'(m_s2);
			big_s3  <= big_s2;
		end
	end
endmodule

// ----- hdl/ray_annulus_intersect.sv -----
// The pipeline is made of three setup stages, a row of 31 division cells that each settle
// one bit of t, three hit point stages, a sum stage and the output register. A new ray can
// be accepted in every cycle unless a result waits at output and is not taken; only then
// does the whole pipeline hold. The user must write configuration through cfg_we, cfg_idx
// and cfg_data while no ray is in flight, which the block does not enforce; index 0 to 7
// follows the register order center, normal, inner and outer squares.
module ray_annulus_intersect import rai_pkg::*; #(
	parameter int MIN_DISTANCE  = 66,
	parameter int FRACTION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [62:0] cfg_data,
	rai_ray_if.snk      ray,
	rai_res_if.src      res
);
	localparam int NW = 53 + FRACTION_BITS;
	localparam int W  = ((NW > 83) ? NW : 83) + 1;

	coord_t             center_q [3];
	logic signed [17:0] normal_q [3];
	logic [62:0]        inner_q;
	logic [62:0]        outer_q;

	logic adv;
	assign adv       = !res.valid || res.ready;
	assign ray.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q[0] <= '0;
			center_q[1] <= '0;
			center_q[2] <= '0;
			normal_q[0] <= '0;
			normal_q[1] <= '0;
			normal_q[2] <= 18'sd65536;
			inner_q     <= '0;
			outer_q     <= 63'd4294967296;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_CENTER_X: center_q[0] <= cfg_data[31:0];
				REG_CENTER_Y: center_q[1] <= cfg_data[31:0];
				REG_CENTER_Z: center_q[2] <= cfg_data[31:0];
				REG_NORMAL_X: normal_q[0] <= cfg_data[17:0];
				REG_NORMAL_Y: normal_q[1] <= cfg_data[17:0];
				REG_NORMAL_Z: normal_q[2] <= cfg_data[17:0];
				REG_INNER_SQ: inner_q     <= cfg_data;
				REG_OUTER_SQ: outer_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	item_t in_it;
	always_comb begin
		in_it        = '0;
		in_it.p[0]   = ray.data.origin_x;
		in_it.p[1]   = ray.data.origin_y;
		in_it.p[2]   = ray.data.origin_z;
		in_it.d[0]   = ray.data.dir_x;
		in_it.d[1]   = ray.data.dir_y;
		in_it.d[2]   = ray.data.dir_z;
	end

	logic               v_s1, v_s2, v_s3;
	item_t              it_s1, it_s2, it_s3;
	logic signed [49:0] nd_s1 [3];
	logic signed [50:0] nc_s1 [3];
	logic signed [51:0] den_s2;
	logic signed [52:0] num_s2;
	logic [W-1:0]       r_s3, b_s3;

	logic [52:0]  a_mag;
	logic [51:0]  b_mag;
	logic [W-1:0] n_w, b_w;
	logic [1:0]   rsn;
	item_t        it_x;

	always_comb begin
		a_mag = num_s2[52] ? 53'(-num_s2) : 53'(num_s2);
		b_mag = den_s2[51] ? 52'(-den_s2) : 52'(den_s2);
		n_w   = W'(a_mag) << FRACTION_BITS;
		b_w   = W'(b_mag);
		if (den_s2 == '0) begin
			rsn = REASON_PARALLEL;
		end else if (num_s2 == '0 || (num_s2[52] != den_s2[51])) begin
			rsn = REASON_BEHIND;
		end else begin
			rsn = REASON_HIT;
		end
		it_x        = it_s2;
		it_x.reason = rsn;
		it_x.ovf    = n_w >= (b_w << 31);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= ray.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			it_s1 <= in_it;
			for (int i = 0; i < 3; i++) begin
				nd_s1[i] <= normal_q[i] * in_it.d[i];
				nc_s1[i] <= normal_q[i] * (33'(center_q[i]) - 33'(in_it.p[i]));
			end
			it_s2  <= it_s1;
			den_s2 <= 52'(nd_s1[0]) + 52'(nd_s1[1]) + 52'(nd_s1[2]);
			num_s2 <= 53'(nc_s1[0]) + 53'(nc_s1[1]) + 53'(nc_s1[2]);
			it_s3  <= it_x;
			r_s3   <= n_w;
			b_s3   <= b_w;
		end
	end

	logic         v_c  [32];
	logic [W-1:0] r_c  [32];
	logic [W-1:0] b_c  [32];
	logic [30:0]  q_c  [32];
	item_t        it_c [32];

	assign v_c[0]  = v_s3;
	assign r_c[0]  = r_s3;
	assign b_c[0]  = b_s3;
	assign q_c[0]  = '0;
	assign it_c[0] = it_s3;

	for (genvar i = 0; i < 31; i++) begin : g_div
		rai_div_cell #(.W(W), .K(30 - i)) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (adv),
			.v_in  (v_c[i]),
			.r_in  (r_c[i]),
			.b_in  (b_c[i]),
			.q_in  (q_c[i]),
			.it_in (it_c[i]),
			.v_q   (v_c[i+1]),
			.r_q   (r_c[i+1]),
			.b_q   (b_c[i+1]),
			.q_q   (q_c[i+1]),
			.it_q  (it_c[i+1])
		);
	end

	item_t       dv;
	logic [30:0] t_d;
	logic [1:0]  rsn_d;
	assign dv = it_c[31];

	always_comb begin
		t_d   = dv.ovf ? T_MAX : q_c[31];
		rsn_d = dv.reason;
		if (dv.reason == REASON_HIT && t_d < 31'(MIN_DISTANCE)) begin
			rsn_d = REASON_BEHIND;
		end
	end

	logic [63:0] sq_a [3];
	logic        big_a [3];

	for (genvar i = 0; i < 3; i++) begin : g_axis
		rai_axis #(.FRACTION_BITS(FRACTION_BITS)) u_axis (
			.clk   (clk),
			.en    (adv),
			.t     (t_d),
			.p     (dv.p[i]),
			.d     (dv.d[i]),
			.c     (center_q[i]),
			.sq_s3 (sq_a[i]),
			.big_s3(big_a[i])
		);
	end

	logic        v_a1, v_a2, v_a3, v_s4;
	logic [30:0] t_a1, t_a2, t_a3, t_s4;
	logic [1:0]  r_a1, r_a2, r_a3, r_s4;
	logic [63:0] rad_s4;
	logic [65:0] tot;
	logic        valid_q;
	res_t        res_q;
	logic [1:0]  rsn_f;

	assign tot = 66'(sq_a[0]) + 66'(sq_a[1]) + 66'(sq_a[2]);

	always_comb begin
		rsn_f = r_s4;
		if (r_s4 == REASON_HIT &&
				(rad_s4 > 64'(outer_q) || rad_s4 < 64'(inner_q))) begin
			rsn_f = REASON_OUTSIDE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_a1    <= 1'b0;
			v_a2    <= 1'b0;
			v_a3    <= 1'b0;
			v_s4    <= 1'b0;
			valid_q <= 1'b0;
		end else if (adv) begin
			v_a1    <= v_c[31];
			v_a2    <= v_a1;
			v_a3    <= v_a2;
			v_s4    <= v_a3;
			valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_a1 <= t_d;
			r_a1 <= rsn_d;
			t_a2 <= t_a1;
			r_a2 <= r_a1;
			t_a3 <= t_a2;
			r_a3 <= r_a2;
			t_s4 <= t_a3;
			r_s4 <= r_a3;
			if (big_a[0] || big_a[1] || big_a[2] || tot[65:64] != 2'b00) begin
				rad_s4 <= '1;
			end else begin
				rad_s4 <= tot[63:0];
			end
			res_q <= '{hit_flag: rsn_f == REASON_HIT, miss_reason: rsn_f,
				hit_distance: (rsn_f == REASON_HIT) ? t_s4 : 31'd0};
		end
	end

	assign res.valid = valid_q;
	assign res.data  = res_q;

	a_hit_code : assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.data.hit_flag == (res.data.miss_reason == REASON_HIT)))
		else $error("hit flag disagrees with miss reason");

	a_miss_zero : assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.data.hit_flag) |-> (res.data.hit_distance == '0))
		else $error("miss carries a nonzero distance");

	a_hit_min : assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.data.hit_flag) |-> (res.data.hit_distance >= 31'(MIN_DISTANCE)))
		else $error("hit closer than the minimum distance");

	a_enter : assert property (@(posedge clk) disable iff (!arst_n)
		(ray.valid && ray.ready) |=> v_s1)
		else $error("accepted ray did not enter the pipeline");
endmodule
